### sv/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Byte class constants and lead/continuation decode helpers.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  typedef logic [7:0] byte_t;

  // Masks and patterns for byte classes
  localparam byte_t MASK_2     = 8'hC0;
  localparam byte_t MASK_3     = 8'hE0;
  localparam byte_t MASK_4     = 8'hF0;
  localparam byte_t MASK_5     = 8'hF8;
  localparam byte_t MASK_PAIR  = 8'hFE;
  localparam byte_t PAT_CONT   = 8'h80;
  localparam byte_t PAT_LEAD2  = 8'hC0;
  localparam byte_t PAT_LEAD3  = 8'hE0;
  localparam byte_t PAT_LEAD4  = 8'hF0;

  // Leads and second bytes with extra range rules
  localparam byte_t LEAD_E0    = 8'hE0;
  localparam byte_t LEAD_ED    = 8'hED;
  localparam byte_t LEAD_EF    = 8'hEF;
  localparam byte_t LEAD_F0    = 8'hF0;
  localparam byte_t LEAD_F4    = 8'hF4;
  localparam byte_t CONT_A0    = 8'hA0;
  localparam byte_t CONT_8F    = 8'h8F;
  localparam byte_t CONT_BF    = 8'hBF;
  localparam byte_t CONT_BE    = 8'hBE;

  // Lead decode result
  typedef struct packed {
    logic       ok;
    logic [1:0] due;   // continuation bytes that follow
  } lead_dec_t;

  function automatic lead_dec_t decode_lead(input byte_t b);
    lead_dec_t d;
    d.ok  = 1'b1;
    d.due = 2'd0;
    if (b[7] == 1'b0) begin
      d.due = 2'd0;
    end else if ((b & MASK_3) == PAT_LEAD2) begin
      d.ok  = ((b & MASK_PAIR) != PAT_LEAD2);
      d.due = 2'd1;
    end else if ((b & MASK_4) == PAT_LEAD3) begin
      d.due = 2'd2;
    end else if ((b & MASK_5) == PAT_LEAD4) begin
      d.ok  = (b <= LEAD_F4);
      d.due = 2'd3;
    end else begin
      d.ok  = 1'b0;
    end
    return d;
  endfunction

  // Continuation byte check given sequence context
  function automatic logic cont_ok(input byte_t b, input byte_t lead,
                                   input logic [1:0] pos, input logic sec_bf);
    logic ok;
    ok = ((b & MASK_2) == PAT_CONT);
    if (pos == 2'd1) begin
      if (lead == LEAD_E0 && (b & MASK_3) == PAT_CONT) ok = 1'b0;
      if (lead == LEAD_ED && (b & MASK_3) == CONT_A0)  ok = 1'b0;
      if (lead == LEAD_F0 && (b & MASK_4) == PAT_CONT) ok = 1'b0;
      if (lead == LEAD_F4 && b > CONT_8F)              ok = 1'b0;
    end else if (pos == 2'd2) begin
      if (lead == LEAD_EF && sec_bf && (b & MASK_PAIR) == CONT_BE) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

### sv/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Checks a buffer of bytes for well-formed UTF-8, one verdict per buffer.
// ----------------------------------------------------------------------------
// Feed the buffer one byte per beat on the byte channel, with last_byte set on
// the final byte. A single verdict beat comes out for each buffer: valid_res
// is 1 when every sequence was well formed and none was left open at the end.
// Rejected are C0/C1 and F5..FF leads, overlong 3- and 4-byte forms,
// surrogates, U+FFFE/U+FFFF, code points above U+10FFFF, stray continuation
// bytes and a truncated final sequence. Once an error is seen the rest of the
// buffer is skipped until the final byte. An empty buffer cannot be sent and
// must be handled in software. The block takes one byte every cycle while no
// final byte waits on a stalled verdict. A byte goes through an input register
// and one level of decode logic; the verdict is registered. Only the final byte
// of a buffer waits on a stalled verdict; all other bytes keep flowing.
// ----------------------------------------------------------------------------
module utf8_stream_validator
  import utf8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  // verdict channel
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output logic       valid_res
);

  // Input register
  logic       ir_valid;
  byte_t      ir_byte;
  logic       ir_last;

  // Sequence state
  logic [1:0] bytes_remaining, bytes_remaining_next;
  byte_t      lead_value, lead_value_next;
  logic [1:0] seq_position, seq_position_next;
  logic       second_was_bf, second_was_bf_next;
  logic       error_seen, error_seen_next;

  logic       ir_move;
  logic       ir_load;
  lead_dec_t  ld;
  logic       verdict;

  // A non-final byte never needs the verdict register; the final one waits
  // until it is free.
  assign ir_move    = ir_valid && (!ir_last || !(verdict_valid && verdict_stall));
  assign byte_stall = ir_valid && !ir_move;
  assign ir_load    = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (ir_load) begin
      ir_valid <= 1'b1;
    end else if (ir_move) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ir_load) begin
      ir_byte <= data_byte;
      ir_last <= last_byte;
    end
  end

  // Per-byte decode
  always_comb begin
    ld                   = decode_lead(ir_byte);
    bytes_remaining_next = bytes_remaining;
    lead_value_next      = lead_value;
    seq_position_next    = seq_position;
    second_was_bf_next   = second_was_bf;
    error_seen_next      = error_seen;
    if (!error_seen) begin
      if (bytes_remaining == 2'd0) begin
        if (ld.ok) begin
          bytes_remaining_next = ld.due;
          lead_value_next      = ir_byte;
          seq_position_next    = 2'd1;
          second_was_bf_next   = 1'b0;
        end else begin
          error_seen_next = 1'b1;
        end
      end else begin
        if (cont_ok(ir_byte, lead_value, seq_position, second_was_bf)) begin
          if (seq_position == 2'd1) begin
            second_was_bf_next = (ir_byte == CONT_BF);
          end
          bytes_remaining_next = bytes_remaining - 2'd1;
          seq_position_next    = seq_position + 2'd1;
        end else begin
          error_seen_next = 1'b1;
        end
      end
    end
    verdict = !error_seen_next && (bytes_remaining_next == 2'd0);
  end

  // State update; the final byte returns everything to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      lead_value      <= '0;
      seq_position    <= 2'd0;
      second_was_bf   <= 1'b0;
      error_seen      <= 1'b0;
    end else if (ir_move) begin
      if (ir_last) begin
        bytes_remaining <= 2'd0;
        lead_value      <= '0;
        seq_position    <= 2'd0;
        second_was_bf   <= 1'b0;
        error_seen      <= 1'b0;
      end else begin
        bytes_remaining <= bytes_remaining_next;
        lead_value      <= lead_value_next;
        seq_position    <= seq_position_next;
        second_was_bf   <= second_was_bf_next;
        error_seen      <= error_seen_next;
      end
    end
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (ir_move && ir_last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ir_move && ir_last) begin
      valid_res <= verdict;
    end
  end

endmodule
